// ===== design/ocpg_pkg.sv =====
// Shared types and constants for the overcurrent peg trip guard.
package ocpg_pkg;

	localparam int unsigned ADC_W     = 12;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned RUN_W     = 16;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned STATE_W   = 2;
	localparam int unsigned S_DATA_W  = 56;
	localparam int unsigned M_DATA_W  = 40;

	localparam logic [ADC_W-1:0] ADC_TOP    = 12'd4095;
	localparam logic [ADC_W-1:0] ADC_BOTTOM = 12'd0;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TRIP_RUN_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME_MS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLE_TIME_MS  = 2'd2;

	localparam logic [CFG_W-1:0] TRIP_RUN_LIMIT_RST = 16'd8;
	localparam logic [CFG_W-1:0] HOLD_TIME_MS_RST   = 16'd200;
	localparam logic [CFG_W-1:0] CYCLE_TIME_MS_RST  = 16'd1000;

	// reported state codes
	localparam logic [STATE_W-1:0] CODE_ARMED = 2'd0;
	localparam logic [STATE_W-1:0] CODE_HOLD  = 2'd1;
	localparam logic [STATE_W-1:0] CODE_BLANK = 2'd2;

	typedef enum logic [2:0] {
		GUARD_ARMED = 3'b001,
		GUARD_HOLD  = 3'b010,
		GUARD_BLANK = 3'b100
	} guard_mode_t;

	typedef struct packed {
		logic [TIME_W-1:0]  trip_total;
		logic [STATE_W-1:0] guard_state;
		logic               force_safe;
	} result_t;

	function automatic logic [STATE_W-1:0] mode_code(input guard_mode_t m);
		logic [STATE_W-1:0] c;
		unique case (m)
			GUARD_ARMED: c = CODE_ARMED;
			GUARD_HOLD:  c = CODE_HOLD;
			GUARD_BLANK: c = CODE_BLANK;
			default:     c = CODE_ARMED;
		endcase
		return c;
	endfunction

	function automatic logic is_pegged(input logic [ADC_W-1:0] v);
		return (v == ADC_BOTTOM) || (v == ADC_TOP);
	endfunction

endpackage

// ===== design/overcurrent_peg_trip_guard_core.sv =====
// Overcurrent peg trip guard: input register, single-pass update, result register.
//
// channel  dir  handshake            payload
// s_       in   s_tvalid / s_tready  s_tdata {now_ms, y_current, x_current}, s_tuser, s_tlast
// m_       out  m_tvalid / m_tready  m_tdata {trip_total, guard_state, force_safe}
// cfg_     in   cfg_we               cfg_index, cfg_data
//
// One word a cycle unless stalled: a word is held in the input register, then updates the
// guard state; a word with tlast loads the result register, seen on m_ the cycle after.
// The input stage stalls only when a tlast word meets a full result register that is
// not being drained.
// Reset clears the guard state, the trip count and both stages, and loads the
// register defaults.
module overcurrent_peg_trip_guard_core
	import ocpg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,   // x_current[11:0], y_current[23:12], now_ms[55:24]
	input  logic                 s_tuser,   // first_in_block
	input  logic                 s_tlast,   // last_in_block
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata,   // force_safe[0], guard_state[2:1], trip_total[34:3]
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0] trip_run_limit_q, hold_time_ms_q, cycle_time_ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trip_run_limit_q <= TRIP_RUN_LIMIT_RST;
			hold_time_ms_q   <= HOLD_TIME_MS_RST;
			cycle_time_ms_q  <= CYCLE_TIME_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRIP_RUN_LIMIT: trip_run_limit_q <= cfg_data;
				REG_HOLD_TIME_MS:   hold_time_ms_q   <= cfg_data;
				REG_CYCLE_TIME_MS:  cycle_time_ms_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage
	logic              valid_s1;
	logic [ADC_W-1:0]  x_s1, y_s1;
	logic [TIME_W-1:0] now_s1;
	logic              first_s1, last_s1;

	// guard state
	guard_mode_t       mode_q;
	logic [RUN_W-1:0]  peg_run_q;
	logic [TIME_W-1:0] trip_time_q;
	logic [TIME_W-1:0] trip_counter_q;
	logic              block_done_q;

	// result register
	logic              out_valid_q;
	result_t           out_data_q;

	logic proceed;
	assign proceed  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || proceed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			x_s1     <= s_tdata[ADC_W-1:0];
			y_s1     <= s_tdata[2*ADC_W-1:ADC_W];
			now_s1   <= s_tdata[2*ADC_W+TIME_W-1:2*ADC_W];
			first_s1 <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	// single-pass update
	guard_mode_t       mode_n;
	logic [RUN_W-1:0]  run_n, run_inc;
	logic [TIME_W-1:0] trip_time_n, counter_n, elapsed;
	logic              done_n;

	always_comb begin
		mode_n      = mode_q;
		run_n       = peg_run_q;
		trip_time_n = trip_time_q;
		counter_n   = trip_counter_q;
		done_n      = block_done_q;
		elapsed     = now_s1 - trip_time_q;
		run_inc     = peg_run_q + 1'b1;

		if (first_s1) begin
			done_n = 1'b0;
			unique case (mode_q)
				GUARD_HOLD: begin
					if (elapsed >= {{(TIME_W-CFG_W){1'b0}}, hold_time_ms_q}) begin
						mode_n = GUARD_BLANK;
						run_n  = '0;
					end
				end
				GUARD_BLANK: begin
					if (elapsed >= {{(TIME_W-CFG_W){1'b0}}, cycle_time_ms_q})
						mode_n = GUARD_ARMED;
				end
				default: ;
			endcase
		end

		// a re-arm at block start cannot also clear the run, so run_n is still peg_run_q here
		if (mode_n == GUARD_ARMED && !done_n) begin
			if (is_pegged(x_s1) || is_pegged(y_s1)) begin
				run_n = run_inc;
				if (run_inc > trip_run_limit_q) begin
					mode_n      = GUARD_HOLD;
					trip_time_n = now_s1;
					counter_n   = trip_counter_q + 1'b1;
					run_n       = '0;
					done_n      = 1'b1;
				end
			end else begin
				run_n = '0;
			end
		end

		if (last_s1)
			done_n = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= GUARD_ARMED;
			peg_run_q      <= '0;
			trip_time_q    <= '0;
			trip_counter_q <= '0;
			block_done_q   <= 1'b0;
		end else if (proceed) begin
			mode_q         <= mode_n;
			peg_run_q      <= run_n;
			trip_time_q    <= trip_time_n;
			trip_counter_q <= counter_n;
			block_done_q   <= done_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proceed && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && last_s1) begin
			out_data_q.force_safe  <= (mode_n == GUARD_HOLD);
			out_data_q.guard_state <= mode_code(mode_n);
			out_data_q.trip_total  <= counter_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_DATA_W-$bits(result_t)){1'b0}}, out_data_q};

endmodule
